// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the RTL; empty when synthesising.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property checked on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");

// Expression that must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_CLK(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, expr)

`endif

`endif

// ----- hw/rtl/rgba_fs_pkg.sv -----
// Package for the RGBA fade sequencer: codes, bounds and saturating step helpers.
package rgba_fs_pkg;

    typedef logic [7:0] chan_t;
    typedef logic [8:0] delta_t;
    typedef logic [4:0] step_t;

    localparam logic OP_START = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    localparam logic [1:0] PHASE_MORNING   = 2'd0;
    localparam logic [1:0] PHASE_AFTERNOON = 2'd1;
    localparam logic [1:0] PHASE_EVENING   = 2'd2;
    localparam logic [1:0] PHASE_NIGHT     = 2'd3;

    localparam chan_t CHAN_MAX       = 8'd255;
    localparam chan_t CHAN_MIN       = 8'd0;
    localparam chan_t MORNING_ALPHA  = 8'd15;
    localparam chan_t AFTERNOON_ALPHA = 8'd25;
    localparam chan_t EVENING_ALPHA  = 8'd50;
    localparam chan_t EVENING_GREEN  = 8'd128;
    localparam chan_t NIGHT_ALPHA    = 8'd150;

    localparam step_t STEP_RESET = 5'd1;

    // v + d, clipped at cap
    function automatic chan_t sat_up(chan_t v, delta_t d, chan_t cap);
        logic [9:0] sum;
        sum = {2'b00, v} + {1'b0, d};
        if (sum > {2'b00, cap})
            return cap;
        return sum[7:0];
    endfunction

    // v - d, clipped at floor_v
    function automatic chan_t sat_down(chan_t v, delta_t d, chan_t floor_v);
        logic [9:0] lim;
        lim = {2'b00, floor_v} + {1'b0, d};
        if ({2'b00, v} < lim)
            return floor_v;
        return v - d[7:0];
    endfunction

endpackage

// ----- hw/rtl/rgba_fade_sequencer_top.sv -----
// RGBA fade sequencer: start/tick requests stepping a tint through four phases.
// A request is held in the input stage registers; its result is registered in the result stage when that loads.
// Throughput: one request per cycle unless out_stall holds the result stage; the colour/phase/running
// state updates in the same cycle the result register loads, so back-to-back ticks see fresh state.
// Reset: levels, phase and running clear to zero, step size to 1, both stages empty.
`include "assert_macros.svh"

module rgba_fade_sequencer_top
    import rgba_fs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,

    input  logic       step_size_we,
    input  logic [4:0] step_size,

    input  logic       in_valid,
    output logic       in_stall,
    input  logic       op,
    input  logic [1:0] target_phase,
    input  logic [7:0] in_red,
    input  logic [7:0] in_green,
    input  logic [7:0] in_blue,
    input  logic [7:0] in_alpha,

    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_red,
    output logic [7:0] out_green,
    output logic [7:0] out_blue,
    output logic [7:0] out_alpha,
    output logic       color_written,
    output logic       active,
    output logic       finished
);

    step_t      step_reg;

    // input stage
    logic       s1_valid_reg;
    logic       op_reg;
    logic [1:0] tphase_reg;
    chan_t      in_red_reg, in_green_reg, in_blue_reg, in_alpha_reg;

    // sequencer state
    chan_t      red_reg, green_reg, blue_reg, alpha_reg;
    logic [1:0] phase_reg;
    logic       running_reg;

    chan_t      red_next, green_next, blue_next, alpha_next;
    logic [1:0] phase_next;
    logic       running_next;
    logic       written_next, finished_next;

    // result stage
    logic       out_valid_reg;
    logic       written_reg, finished_reg;

    logic       in_accept;
    logic       s2_load;
    logic       done;
    delta_t     d1, d3, d6, d10;

    assign s2_load   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !s2_load;
    assign in_accept = in_valid && !in_stall;

    assign d1  = {4'b0000, step_reg};
    assign d3  = delta_t'({4'b0000, step_reg} * 9'd3);
    assign d6  = delta_t'({4'b0000, step_reg} * 9'd6);
    assign d10 = delta_t'({4'b0000, step_reg} * 9'd10);

    always_comb
    begin
        red_next      = red_reg;
        green_next    = green_reg;
        blue_next     = blue_reg;
        alpha_next    = alpha_reg;
        phase_next    = phase_reg;
        running_next  = running_reg;
        written_next  = 1'b0;
        finished_next = 1'b0;
        done          = 1'b0;

        if (op_reg == OP_START)
        begin
            phase_next   = tphase_reg;
            red_next     = in_red_reg;
            green_next   = in_green_reg;
            blue_next    = in_blue_reg;
            alpha_next   = in_alpha_reg;
            running_next = 1'b1;
        end
        else if (running_reg)
        begin
            // all compares use the levels from before this tick
            case (phase_reg)
                PHASE_MORNING:
                begin
                    if (alpha_reg > MORNING_ALPHA)
                        alpha_next = sat_down(alpha_reg, d1, MORNING_ALPHA);
                    if (blue_reg < CHAN_MAX)
                        blue_next = sat_up(blue_reg, d1, CHAN_MAX);
                    else
                        done = 1'b1;
                end
                PHASE_AFTERNOON:
                begin
                    if (alpha_reg < AFTERNOON_ALPHA)
                        alpha_next = sat_up(alpha_reg, d10, AFTERNOON_ALPHA);
                    // of green, blue and red, only the first unmet channel moves
                    if (green_reg < CHAN_MAX)
                        green_next = sat_up(green_reg, d10, CHAN_MAX);
                    else if (blue_reg > CHAN_MIN)
                        blue_next = sat_down(blue_reg, d10, CHAN_MIN);
                    else if (red_reg < CHAN_MAX)
                        red_next = sat_up(red_reg, d10, CHAN_MAX);
                    else
                        done = 1'b1;
                end
                PHASE_EVENING:
                begin
                    if (alpha_reg < EVENING_ALPHA)
                        alpha_next = sat_up(alpha_reg, d1, EVENING_ALPHA);
                    if (green_reg > EVENING_GREEN)
                        green_next = sat_down(green_reg, d1, EVENING_GREEN);
                    else
                        done = 1'b1;
                end
                default:
                begin
                    if (alpha_reg < NIGHT_ALPHA)
                        alpha_next = sat_up(alpha_reg, d1, NIGHT_ALPHA);
                    if (red_reg != CHAN_MIN)
                        red_next = sat_down(red_reg, d6, CHAN_MIN);
                    if (green_reg != CHAN_MIN)
                        green_next = sat_down(green_reg, d3, CHAN_MIN);
                    done = (alpha_reg >= NIGHT_ALPHA) && (red_reg == CHAN_MIN)
                           && (green_reg == CHAN_MIN);
                end
            endcase

            if (done)
            begin
                running_next  = 1'b0;
                finished_next = 1'b1;
            end
            else
                written_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= STEP_RESET;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            red_reg       <= CHAN_MIN;
            green_reg     <= CHAN_MIN;
            blue_reg      <= CHAN_MIN;
            alpha_reg     <= CHAN_MIN;
            phase_reg     <= PHASE_MORNING;
            running_reg   <= 1'b0;
        end
        else
        begin
            if (step_size_we)
                step_reg <= step_size;

            if (in_accept)
                s1_valid_reg <= 1'b1;
            else if (s2_load)
                s1_valid_reg <= 1'b0;

            if (s2_load)
            begin
                out_valid_reg <= 1'b1;
                red_reg       <= red_next;
                green_reg     <= green_next;
                blue_reg      <= blue_next;
                alpha_reg     <= alpha_next;
                phase_reg     <= phase_next;
                running_reg   <= running_next;
            end
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            op_reg       <= op;
            tphase_reg   <= target_phase;
            in_red_reg   <= in_red;
            in_green_reg <= in_green;
            in_blue_reg  <= in_blue;
            in_alpha_reg <= in_alpha;
        end
        if (s2_load)
        begin
            written_reg  <= written_next;
            finished_reg <= finished_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_red       = red_reg;
    assign out_green     = green_reg;
    assign out_blue      = blue_reg;
    assign out_alpha     = alpha_reg;
    assign color_written = written_reg;
    assign active        = running_reg;
    assign finished      = finished_reg;

    `ASSERT_NEVER(a_fin_and_written, clk, rst_n, out_valid_reg && finished_reg && written_reg)
    `ASSERT_NEVER(a_fin_while_active, clk, rst_n, out_valid_reg && finished_reg && running_reg)
    `ASSERT_CLK(a_idle_tick_quiet, clk, rst_n, (s2_load && op_reg == OP_TICK && !running_reg) |=> (!written_reg && !finished_reg && !running_reg))

endmodule

// ----- sim/tb_rgba_fade_sequencer_top.sv -----
// Self-checking testbench for the RGBA fade sequencer: random requests, stalls, step sizes.
`timescale 1ns / 100ps

module tb_rgba_fade_sequencer_top
    import rgba_fs_pkg::*;
();

    localparam int unsigned CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic       op;
        logic [1:0] phase;
        chan_t      red;
        chan_t      green;
        chan_t      blue;
        chan_t      alpha;
    } fade_req_t;

    typedef struct packed {
        chan_t red;
        chan_t green;
        chan_t blue;
        chan_t alpha;
        logic  written;
        logic  active;
        logic  finished;
    } fade_result_t;

    logic       clk;
    logic       rst_n;
    logic       step_size_we;
    logic [4:0] step_size;
    logic       in_valid;
    logic       in_stall;
    logic       op;
    logic [1:0] target_phase;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
    logic [7:0] in_alpha;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
    logic       color_written;
    logic       active;
    logic       finished;

    fade_req_t    pend_q[$];
    fade_result_t fade_q[$];
    fade_req_t    cur_req;
    int unsigned  burst_left = 8;
    int unsigned  gap_left = 0;
    int unsigned  stall_mode = 0;
    int unsigned  stall_tick = 0;
    int unsigned  cycles = 0;
    int unsigned  errors = 0;

    // predictor state
    chan_t      lvl_r = '0;
    chan_t      lvl_g = '0;
    chan_t      lvl_b = '0;
    chan_t      lvl_a = '0;
    logic [1:0] fade_phase = PHASE_MORNING;
    logic       fading = 1'b0;
    step_t      step_cfg = STEP_RESET;

    rgba_fade_sequencer_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .step_size_we  (step_size_we),
        .step_size     (step_size),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .op            (op),
        .target_phase  (target_phase),
        .in_red        (in_red),
        .in_green      (in_green),
        .in_blue       (in_blue),
        .in_alpha      (in_alpha),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_red       (out_red),
        .out_green     (out_green),
        .out_blue      (out_blue),
        .out_alpha     (out_alpha),
        .color_written (color_written),
        .active        (active),
        .finished      (finished)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic chan_t clip_add(chan_t v, int unsigned d, chan_t cap);
        if (int'(v) + d > int'(cap))
            return cap;
        return chan_t'(int'(v) + d);
    endfunction

    function automatic chan_t clip_sub(chan_t v, int unsigned d, chan_t flr);
        if (int'(v) < int'(flr) + d)
            return flr;
        return chan_t'(int'(v) - d);
    endfunction

    // One phase step on the predictor levels; returns 1 when the goal was already met.
    function automatic logic fade_tick();
        int unsigned s;
        logic        done;
        logic        a_ok;
        logic        r_ok;
        logic        g_ok;
        s = 32'(step_cfg);
        done = 1'b0;
        case (fade_phase)
            PHASE_MORNING:
            begin
                if (lvl_a > MORNING_ALPHA)
                    lvl_a = clip_sub(lvl_a, s, MORNING_ALPHA);
                if (lvl_b < CHAN_MAX)
                    lvl_b = clip_add(lvl_b, s, CHAN_MAX);
                else
                    done = 1'b1;
            end
            PHASE_AFTERNOON:
            begin
                if (lvl_a < AFTERNOON_ALPHA)
                    lvl_a = clip_add(lvl_a, s * 10, AFTERNOON_ALPHA);
                // of green, blue and red, only the first move that applies
                if (lvl_g < CHAN_MAX)
                    lvl_g = clip_add(lvl_g, s * 10, CHAN_MAX);
                else if (lvl_b > CHAN_MIN)
                    lvl_b = clip_sub(lvl_b, s * 10, CHAN_MIN);
                else if (lvl_r < CHAN_MAX)
                    lvl_r = clip_add(lvl_r, s * 10, CHAN_MAX);
                else
                    done = 1'b1;
            end
            PHASE_EVENING:
            begin
                if (lvl_a < EVENING_ALPHA)
                    lvl_a = clip_add(lvl_a, s, EVENING_ALPHA);
                if (lvl_g > EVENING_GREEN)
                    lvl_g = clip_sub(lvl_g, s, EVENING_GREEN);
                else
                    done = 1'b1;
            end
            default:
            begin
                // night: goals judged before any channel moves
                a_ok = lvl_a >= NIGHT_ALPHA;
                r_ok = lvl_r == CHAN_MIN;
                g_ok = lvl_g == CHAN_MIN;
                if (!a_ok)
                    lvl_a = clip_add(lvl_a, s, NIGHT_ALPHA);
                if (!r_ok)
                    lvl_r = clip_sub(lvl_r, s * 6, CHAN_MIN);
                if (!g_ok)
                    lvl_g = clip_sub(lvl_g, s * 3, CHAN_MIN);
                done = a_ok && r_ok && g_ok;
            end
        endcase
        return done;
    endfunction

    function automatic fade_result_t advance_fade(fade_req_t rq);
        fade_result_t res;
        res = '0;
        if (rq.op == OP_START)
        begin
            fade_phase = rq.phase;
            lvl_r = rq.red;
            lvl_g = rq.green;
            lvl_b = rq.blue;
            lvl_a = rq.alpha;
            fading = 1'b1;
        end
        else if (fading)
        begin
            if (fade_tick())
            begin
                fading = 1'b0;
                res.finished = 1'b1;
            end
            else
            begin
                res.written = 1'b1;
            end
        end
        res.red = lvl_r;
        res.green = lvl_g;
        res.blue = lvl_b;
        res.alpha = lvl_a;
        res.active = fading;
        return res;
    endfunction

    function automatic string show_res(fade_result_t r);
        return $sformatf("r%0d g%0d b%0d a%0d w%b a%b f%b", r.red, r.green, r.blue,
                         r.alpha, r.written, r.active, r.finished);
    endfunction

    task automatic report(string what, fade_result_t got, fade_result_t want);
        errors++;
        if (errors <= 40)
            $display("%0d: %s: got %s, exp %s", cycles, what, show_res(got), show_res(want));
    endtask

    // Sender: bursts of requests with random gaps; also tracks the step size register.
    always @(posedge clk)
    begin : send_proc
        fade_req_t nxt;
        bit        fire;
        if (rst_n)
        begin
            if (step_size_we)
                step_cfg = step_size;
            fire = in_valid && !in_stall;
            if (fire)
                fade_q.push_back(advance_fade(cur_req));
            if (!in_valid || fire)
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pend_q.size() != 0)
                begin
                    nxt = pend_q.pop_front();
                    cur_req = nxt;
                    op <= nxt.op;
                    target_phase <= nxt.phase;
                    in_red <= nxt.red;
                    in_green <= nxt.green;
                    in_blue <= nxt.blue;
                    in_alpha <= nxt.alpha;
                    in_valid <= 1'b1;
                    if (burst_left <= 1)
                    begin
                        if ($urandom_range(0, 9) == 0)
                        begin
                            burst_left = 120;
                            gap_left = 0;
                        end
                        else
                        begin
                            burst_left = $urandom_range(1, 30);
                            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                        end
                    end
                    else
                    begin
                        burst_left--;
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each result and stalls on a shifting pattern.
    always @(posedge clk)
    begin : watch_proc
        fade_result_t got;
        fade_result_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                got = '{out_red, out_green, out_blue, out_alpha, color_written, active, finished};
                if (fade_q.size() == 0)
                begin
                    report("result with no request pending", got, got);
                end
                else
                begin
                    want = fade_q.pop_front();
                    if (got !== want)
                        report("result mismatch", got, want);
                end
            end
            stall_tick++;
            if (stall_tick % 97 == 0)
                stall_mode = $urandom_range(0, 2);
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                default: out_stall <= ((stall_tick % 7) < 3);
            endcase
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic push_req(logic o, logic [1:0] ph, chan_t r, chan_t g, chan_t b, chan_t a);
        pend_q.push_back('{o, ph, r, g, b, a});
    endtask

    task automatic push_tick();
        push_req(OP_TICK, 2'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    // Biased towards the phase goals and channel bounds.
    function automatic chan_t pick_level();
        chan_t marks[10] = '{8'd0, 8'd1, 8'd254, 8'd255, 8'd14, 8'd15, 8'd25, 8'd50,
                             8'd128, 8'd150};
        chan_t v;
        if ($urandom_range(0, 2) == 0)
            v = marks[4'($urandom_range(0, 9))];
        else
            v = 8'($urandom);
        return v;
    endfunction

    // Mostly start-then-ticks sequences, some loose noise.
    task automatic push_random(int unsigned n);
        int unsigned made;
        int unsigned ticks;
        made = 0;
        while (made < n)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                push_req(1'($urandom), 2'($urandom), 8'($urandom), 8'($urandom),
                         8'($urandom), 8'($urandom));
                made++;
            end
            else
            begin
                push_req(OP_START, 2'($urandom), pick_level(), pick_level(), pick_level(),
                         pick_level());
                ticks = $urandom_range(1, 48);
                repeat (ticks) push_tick();
                made += ticks + 1;
            end
        end
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pend_q.size() != 0 || in_valid || fade_q.size() != 0);
    endtask

    task automatic write_step(step_t v);
        @(posedge clk);
        step_size_we <= 1'b1;
        step_size <= v;
        @(posedge clk);
        step_size_we <= 1'b0;
        @(negedge clk);
    endtask

    // Sender holds off half-way until every result is back.
    task automatic run_phase(step_t v, int unsigned n);
        write_step(v);
        push_random(n / 2);
        wait_drained();
        push_random(n - n / 2);
        wait_drained();
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        step_size_we = 1'b0;
        step_size = '0;
        in_valid = 1'b0;
        op = OP_TICK;
        target_phase = PHASE_MORNING;
        in_red = '0;
        in_green = '0;
        in_blue = '0;
        in_alpha = '0;
        out_stall = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed, step size 1 from reset
        push_req(OP_TICK, PHASE_NIGHT, 8'hff, 8'hff, 8'hff, 8'hff);          // idle tick
        push_req(OP_START, PHASE_MORNING, 8'h00, 8'h00, 8'hfe, 8'hff);
        push_tick();
        push_tick();                                                        // blue at top: ends
        push_tick();                                                        // idle again
        push_req(OP_START, PHASE_AFTERNOON, 8'hff, 8'hff, 8'h01, 8'h00);
        push_tick();                                                        // blue falls
        push_tick();                                                        // all met
        push_req(OP_START, PHASE_AFTERNOON, 8'h00, 8'hff, 8'h00, 8'h18);
        push_tick();                                                        // red rises
        push_req(OP_START, PHASE_AFTERNOON, 8'h00, 8'h00, 8'hff, 8'h00);
        push_tick();                                                        // green first
        push_req(OP_START, PHASE_EVENING, 8'h55, 8'h81, 8'h00, 8'h31);
        push_tick();
        push_tick();
        push_req(OP_START, PHASE_NIGHT, 8'h06, 8'h03, 8'h00, 8'h95);
        push_tick();
        push_tick();
        push_req(OP_START, PHASE_NIGHT, 8'hff, 8'hff, 8'hff, 8'hff);
        push_tick();
        push_req(OP_START, PHASE_MORNING, 8'h00, 8'h00, 8'h00, 8'h00);     // restart mid-fade
        push_tick();
        wait_drained();

        run_phase(5'd25, 180);
        run_phase(5'd0, 120);
        run_phase(5'd31, 150);
        run_phase(5'd1, 180);
        repeat (3) run_phase(step_t'($urandom_range(1, 25)), 180);
        run_phase(step_t'($urandom_range(0, 31)), 150);

        repeat (4) @(negedge clk);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
